// ===== src/ivir_pkg.sv =====
// Shared types and constants for the indexed vector insert/remove block.
package ivir_pkg;

    localparam int OPC_W    = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [OPC_W-1:0] {
        OP_APPEND = 3'd0,
        OP_READ   = 3'd1,
        OP_WRITE  = 3'd2,
        OP_INSERT = 3'd3,
        OP_REMOVE = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SH_RD,
        S_SH_WR
    } t_state;

endpackage

// ===== src/indexed_vector_insert_remove.sv =====
// Top level: ordered element array with append, read, write, insert and remove.
//
// A request is taken when start is high and busy is low; its single result appears
// on o_read_data, o_status and o_count for exactly one cycle with o_valid high, and
// cannot be held off. Append, write, and any request that ends in an error give
// their result from the execute state; a read first passes through a read state.
// Insert at position p moves the elements from p upward, remove moves those above p
// down: the elements are moved one at a time through the element store, a read
// and a write per element, under a small sequencer with one shared index adder.
// busy drops in the cycle the result is shown, so the next request may be taken
// there. No clearing pass is needed after reset.
module indexed_vector_insert_remove #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ivir_pkg::OPC_W-1:0]    i_opcode,
    input  logic [ivir_pkg::POS_W-1:0]    i_position,
    input  logic [ivir_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_valid,
    output logic [ivir_pkg::VALUE_W-1:0]  o_read_data,
    output logic [ivir_pkg::STATUS_W-1:0] o_status,
    output logic [ivir_pkg::COUNT_W-1:0]  o_count
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > ivir_pkg::POS_W) ? CNT_W : ivir_pkg::POS_W;
    localparam int EXT_W  = (DATA_WIDTH > ivir_pkg::VALUE_W) ? DATA_WIDTH
                                                             : ivir_pkg::VALUE_W;
    localparam int OCW    = (CNT_W > ivir_pkg::COUNT_W) ? CNT_W : ivir_pkg::COUNT_W;

    ivir_pkg::t_state r_state, n_state;

    logic [ivir_pkg::OPC_W-1:0] r_op;
    logic [ivir_pkg::POS_W-1:0] r_pos;
    logic [DATA_WIDTH-1:0]      r_val;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_idx, n_idx;

    logic                          r_valid, n_valid;
    logic [DATA_WIDTH-1:0]         r_rdata, n_rdata;
    logic [ivir_pkg::STATUS_W-1:0] r_status, n_status;
    logic [CNT_W-1:0]              r_ocount;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

    logic [CMP_W-1:0] pos_ext, cnt_ext, idx_ext;
    logic             in_bounds, full, is_insert;
    logic [CNT_W-1:0] idx_step;
    logic [EXT_W-1:0] val_ext, rd_ext;
    logic [OCW-1:0]   cnt_out_ext;
    logic             accept;

    assign accept    = start && !busy;
    assign busy      = (r_state != ivir_pkg::S_IDLE);
    assign pos_ext   = CMP_W'(r_pos);
    assign cnt_ext   = CMP_W'(r_count);
    assign idx_ext   = CMP_W'(r_idx);
    assign in_bounds = pos_ext < cnt_ext;
    assign full      = (r_count == CNT_W'(CAPACITY));
    assign is_insert = (r_op == ivir_pkg::OP_INSERT);
    // shared index unit: insert walks down, remove walks up
    assign idx_step  = is_insert ? (r_idx - CNT_W'(1)) : (r_idx + CNT_W'(1));
    assign val_ext   = EXT_W'(i_value);

    ivir_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ivir_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_opcode;
            r_pos <= i_position;
            r_val <= val_ext[DATA_WIDTH-1:0];
        end
        r_idx <= n_idx;
        if (n_valid) begin
            r_rdata  <= n_rdata;
            r_status <= n_status;
            r_ocount <= n_count;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_valid   = 1'b0;
        n_rdata   = '0;
        n_status  = ivir_pkg::ST_OK;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = pos_ext[ADDR_W-1:0];
        ram_wdata = r_val;
        ram_raddr = pos_ext[ADDR_W-1:0];

        case (r_state)
            ivir_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = ivir_pkg::S_EXEC;
                end
            end

            ivir_pkg::S_EXEC: begin
                n_state = ivir_pkg::S_IDLE;
                n_valid = 1'b1;
                case (r_op)
                    ivir_pkg::OP_APPEND: begin
                        if (full) begin
                            n_status = ivir_pkg::ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[ADDR_W-1:0];
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    ivir_pkg::OP_READ: begin
                        if (!in_bounds) begin
                            n_status = ivir_pkg::ST_BOUNDS;
                        end else begin
                            ram_re  = 1'b1;
                            n_valid = 1'b0;
                            n_state = ivir_pkg::S_READ;
                        end
                    end
                    ivir_pkg::OP_WRITE: begin
                        if (!in_bounds) begin
                            n_status = ivir_pkg::ST_BOUNDS;
                        end else begin
                            ram_we = 1'b1;
                        end
                    end
                    ivir_pkg::OP_INSERT: begin
                        if (!in_bounds) begin
                            n_status = ivir_pkg::ST_BOUNDS;
                        end else if (full) begin
                            n_status = ivir_pkg::ST_FULL;
                        end else begin
                            n_idx   = r_count;
                            n_valid = 1'b0;
                            n_state = ivir_pkg::S_SH_RD;
                        end
                    end
                    ivir_pkg::OP_REMOVE: begin
                        if (!in_bounds) begin
                            n_status = ivir_pkg::ST_BOUNDS;
                        end else begin
                            n_idx   = pos_ext[CNT_W-1:0];
                            n_valid = 1'b0;
                            n_state = ivir_pkg::S_SH_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            ivir_pkg::S_READ: begin
                n_state = ivir_pkg::S_IDLE;
                n_valid = 1'b1;
                n_rdata = ram_rdata;
            end

            ivir_pkg::S_SH_RD: begin
                if (is_insert) begin
                    if (idx_ext > pos_ext) begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_step[ADDR_W-1:0];
                        n_state   = ivir_pkg::S_SH_WR;
                    end else begin
                        // gap opened at the position: drop the new element in
                        ram_we  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        n_valid = 1'b1;
                        n_state = ivir_pkg::S_IDLE;
                    end
                end else begin
                    if (idx_step < r_count) begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_step[ADDR_W-1:0];
                        n_state   = ivir_pkg::S_SH_WR;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                        n_valid = 1'b1;
                        n_state = ivir_pkg::S_IDLE;
                    end
                end
            end

            ivir_pkg::S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[ADDR_W-1:0];
                ram_wdata = ram_rdata;
                n_idx     = idx_step;
                n_state   = ivir_pkg::S_SH_RD;
            end

            default: begin
                n_state = ivir_pkg::S_IDLE;
            end
        endcase
    end

    assign rd_ext      = EXT_W'(r_rdata);
    assign cnt_out_ext = OCW'(r_ocount);

    assign o_valid     = r_valid;
    assign o_read_data = rd_ext[ivir_pkg::VALUE_W-1:0];
    assign o_status    = r_status;
    assign o_count     = cnt_out_ext[ivir_pkg::COUNT_W-1:0];

endmodule

// ===== src/ivir_ram.sv =====
// Element store: one write port, one registered read port.
module ivir_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ivir_checker.sv =====
// Port-level checks for the indexed vector block, bound to the top level.
module ivir_checker #(
    parameter int CAPACITY = 64
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [ivir_pkg::STATUS_W-1:0] o_status,
    input logic [ivir_pkg::COUNT_W-1:0]  o_count
);

    localparam int CW = (ivir_pkg::COUNT_W > 32) ? ivir_pkg::COUNT_W : 32;
    localparam logic [CW-1:0] CAP_EXT = CW'(CAPACITY);
    localparam logic [ivir_pkg::COUNT_W-1:0] CAP_CNT = CAP_EXT[ivir_pkg::COUNT_W-1:0];

    // busy is raised after every request that is taken
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a request was taken");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    // the end of every piece of work shows a result
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ivir_pkg::ST_FULL) |-> (o_count == CAP_CNT))
        else $error("full status with the array not at capacity");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ivir_pkg::ST_OK) || (o_status == ivir_pkg::ST_BOUNDS)
                    || (o_status == ivir_pkg::ST_FULL))
        else $error("undefined status code");

endmodule

bind indexed_vector_insert_remove ivir_checker #(
    .CAPACITY (CAPACITY)
) u_ivir_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_status (o_status),
    .o_count  (o_count)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the indexed vector insert/remove block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic [ivir_pkg::VALUE_W-1:0] rd;
        ivir_pkg::t_status            st;
        logic [ivir_pkg::COUNT_W-1:0] cnt;
    } t_outcome;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [ivir_pkg::OPC_W-1:0]    i_opcode = '0;
    logic [ivir_pkg::POS_W-1:0]    i_position = '0;
    logic [ivir_pkg::VALUE_W-1:0]  i_value = '0;
    logic                          o_valid;
    logic [ivir_pkg::VALUE_W-1:0]  o_read_data;
    logic [ivir_pkg::STATUS_W-1:0] o_status;
    logic [ivir_pkg::COUNT_W-1:0]  o_count;

    // model of the element array
    logic [ivir_pkg::VALUE_W-1:0] elems [CAPACITY];
    int                           held = 0;

    t_outcome pending_outcomes[$];
    bit       gaps_on = 1'b1;
    int       mismatches = 0;
    int       cycles = 0;
    int       requests = 0;
    int       results_checked = 0;
    int       n_ok = 0;
    int       n_bounds = 0;
    int       n_full = 0;

    indexed_vector_insert_remove #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_read_data (o_read_data),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_outcomes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Applies one request to the model and returns the result it should give.
    function automatic t_outcome vector_step(input logic [ivir_pkg::OPC_W-1:0] op,
                                             input logic [ivir_pkg::POS_W-1:0] pos,
                                             input logic [ivir_pkg::VALUE_W-1:0] val);
        t_outcome r;
        logic     hit;
        r.rd = '0;
        r.st = ivir_pkg::ST_OK;
        hit  = (int'(pos) < held);
        case (op)
            ivir_pkg::OP_APPEND: begin
                if (held >= CAPACITY) begin
                    r.st = ivir_pkg::ST_FULL;
                end else begin
                    elems[held] = val;
                    held++;
                end
            end
            ivir_pkg::OP_READ: begin
                if (!hit) r.st = ivir_pkg::ST_BOUNDS;
                else      r.rd = elems[pos];
            end
            ivir_pkg::OP_WRITE: begin
                if (!hit) r.st = ivir_pkg::ST_BOUNDS;
                else      elems[pos] = val;
            end
            ivir_pkg::OP_INSERT: begin
                // bounds first, so insert at the count is never reported full
                if (!hit) begin
                    r.st = ivir_pkg::ST_BOUNDS;
                end else if (held >= CAPACITY) begin
                    r.st = ivir_pkg::ST_FULL;
                end else begin
                    for (int i = held; i > int'(pos); i--) elems[i] = elems[i-1];
                    elems[pos] = val;
                    held++;
                end
            end
            ivir_pkg::OP_REMOVE: begin
                if (!hit) begin
                    r.st = ivir_pkg::ST_BOUNDS;
                end else begin
                    for (int i = int'(pos); i + 1 < held; i++) elems[i] = elems[i+1];
                    held--;
                end
            end
            default: ;
        endcase
        r.cnt = ivir_pkg::COUNT_W'(held);
        return r;
    endfunction

    // Called at a rising edge with nothing yet driven in that step; returns
    // at the edge where the request was taken.
    task automatic send_request(input logic [ivir_pkg::OPC_W-1:0] op,
                                input logic [ivir_pkg::POS_W-1:0] pos,
                                input logic [ivir_pkg::VALUE_W-1:0] val);
        t_outcome r;
        if (gaps_on && $urandom_range(99) < 23) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_opcode   <= op;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (busy);
        r = vector_step(op, pos, val);
        pending_outcomes.push_back(r);
        requests++;
        case (r.st)
            ivir_pkg::ST_OK:     n_ok++;
            ivir_pkg::ST_BOUNDS: n_bounds++;
            default:             n_full++;
        endcase
    endtask

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch($sformatf(
                    "result with no request outstanding: data %h st %0d cnt %0d",
                    o_read_data, o_status, o_count));
            end else begin
                want = pending_outcomes.pop_front();
                results_checked++;
                if (o_read_data !== want.rd)
                    report_mismatch($sformatf("read data %h, expected %h",
                                              o_read_data, want.rd));
                if (o_status !== want.st)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.st));
                if (o_count !== want.cnt)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              o_count, want.cnt));
            end
        end
    end

    function automatic logic [ivir_pkg::VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return '0;
        if (r < 16) return '1;
        return ivir_pkg::VALUE_W'($urandom);
    endfunction

    // Mostly in range, sometimes exactly the count, sometimes anywhere.
    function automatic logic [ivir_pkg::POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(99);
        if (held > 0 && r < 82) return ivir_pkg::POS_W'($urandom_range(held - 1));
        if (held < CAPACITY && r < 90) return ivir_pkg::POS_W'(held);
        return ivir_pkg::POS_W'($urandom_range(CAPACITY - 1));
    endfunction

    task automatic run_mix(input int n, input int grow_pct, input int shrink_pct);
        int                         r;
        logic [ivir_pkg::OPC_W-1:0] op;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < grow_pct)
                op = $urandom_range(1) ? ivir_pkg::OP_APPEND : ivir_pkg::OP_INSERT;
            else if (r < grow_pct + shrink_pct)
                op = ivir_pkg::OP_REMOVE;
            else if ($urandom_range(99) < 8)
                op = ivir_pkg::OPC_W'($urandom_range(ivir_pkg::OP_REMOVE + 1, 7));
            else
                op = $urandom_range(1) ? ivir_pkg::OP_READ : ivir_pkg::OP_WRITE;
            send_request(op, pick_position(), pick_value());
        end
    endtask

    task automatic test_directed();
        // empty array: every indexed access is out of bounds
        send_request(ivir_pkg::OP_READ,   '0, 32'h1234_5678);
        send_request(ivir_pkg::OP_WRITE,  '0, 32'h1234_5678);
        send_request(ivir_pkg::OP_INSERT, '0, 32'h1234_5678);
        send_request(ivir_pkg::OP_REMOVE, '0, '0);
        for (int u = ivir_pkg::OP_REMOVE + 1; u < 8; u++)
            send_request(ivir_pkg::OPC_W'(u), '1, '1);
        send_request(ivir_pkg::OP_APPEND, '0, '0);
        send_request(ivir_pkg::OP_APPEND, '1, '1);
        send_request(ivir_pkg::OP_READ,   6'd0, '0);
        send_request(ivir_pkg::OP_READ,   6'd1, '0);
        send_request(ivir_pkg::OP_READ,   '1, '0);
        send_request(ivir_pkg::OP_INSERT, 6'd2, 32'hDEAD_BEEF);   // at the count: rejected
        send_request(ivir_pkg::OP_INSERT, 6'd0, 32'hA5A5_A5A5);
        send_request(ivir_pkg::OP_WRITE,  6'd1, 32'h5A5A_5A5A);
        send_request(ivir_pkg::OP_READ,   6'd2, '0);
        send_request(ivir_pkg::OP_READ,   6'd1, '0);
        send_request(ivir_pkg::OP_REMOVE, 6'd2, '0);
        send_request(ivir_pkg::OP_REMOVE, 6'd0, '0);
        send_request(ivir_pkg::OP_READ,   6'd0, '0);
        send_request(ivir_pkg::OP_REMOVE, '1, '0);
        send_request(ivir_pkg::OP_REMOVE, 6'd0, '0);
        send_request(ivir_pkg::OP_APPEND, '0, 32'h8000_0001);
    endtask

    task automatic test_fill_to_capacity();
        while (held < CAPACITY)
            send_request(ivir_pkg::OP_APPEND, pick_position(), pick_value());
        send_request(ivir_pkg::OP_APPEND, '0, '1);
        send_request(ivir_pkg::OP_INSERT, 6'd0, '1);
        send_request(ivir_pkg::OP_INSERT, '1, '1);
        send_request(ivir_pkg::OP_WRITE,  '1, 32'hC3C3_3C3C);
        send_request(ivir_pkg::OP_READ,   '1, '0);
        send_request(ivir_pkg::OP_REMOVE, '1, '0);
        // longest shifts: insert at the bottom of a nearly full array, then remove at the bottom of the full one
        send_request(ivir_pkg::OP_INSERT, 6'd0, 32'h0F0F_F0F0);
        send_request(ivir_pkg::OP_READ,   6'd0, '0);
        send_request(ivir_pkg::OP_REMOVE, 6'd0, '0);
        send_request(ivir_pkg::OP_READ,   6'd62, '0);
        while (held > 20) send_request(ivir_pkg::OP_REMOVE, pick_position(), '0);
    endtask

    task automatic test_random_growth();
        run_mix(300, 60, 15);
    endtask

    task automatic test_random_balanced();
        run_mix(300, 35, 35);
    endtask

    task automatic test_random_shrink();
        run_mix(200, 10, 60);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        run_mix(200, 40, 30);
        gaps_on = 1'b1;
    endtask

    task automatic test_near_full();
        run_mix(200, 70, 8);
        run_mix(130, 15, 55);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_fill_to_capacity();
        test_random_growth();
        test_random_balanced();
        test_random_shrink();
        test_back_to_back();
        test_near_full();
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d requests sent (%0d ok, %0d out of bounds, %0d full), %0d results checked",
                 requests, n_ok, n_bounds, n_full, results_checked);
        $display("%0d mismatches over %0d cycles", mismatches, cycles);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/ivir_pkg.sv
src/ivir_ram.sv
src/indexed_vector_insert_remove.sv
src/ivir_checker.sv
sim/testbench.sv
